[rtl/phvc_pkg.sv]
// Shared constants, types and functions of the pose-hold velocity controller.
`default_nettype none

package phvc_pkg;

	// Angle extraction depth; the arctangent table holds 24 entries.
	localparam int ANGLE_ITERS  = 16;
	localparam int CORDIC_STEPS = (ANGLE_ITERS < 24) ? ANGLE_ITERS : 24;

	// Field widths.
	localparam int FUNC_W    = 2;
	localparam int POS_W     = 32;
	localparam int ROW_W     = 48;
	localparam int ROT_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int VEL_W     = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Event codes.
	localparam logic [FUNC_W-1:0] FUNC_POSE     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SAVE     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_HOLD_ON  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_HOLD_OFF = 2'd3;

	// Register indexes.
	localparam logic [1:0] REG_MOVE_GAIN = 2'd0;
	localparam logic [1:0] REG_TURN_GAIN = 2'd1;
	localparam logic [1:0] REG_DEADBAND  = 2'd2;

	// Reset values of the registers.
	localparam logic [GAIN_W-1:0] MOVE_GAIN_RST = 16'd1280;
	localparam logic [GAIN_W-1:0] TURN_GAIN_RST = 16'd64;
	localparam logic [GAIN_W-1:0] DEADBAND_RST  = 16'd131;

	// Destinations of a multiplier product.
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_N2   = 3'd1;
	localparam logic [2:0] DST_ROT  = 3'd2;
	localparam logic [2:0] DST_LIN  = 3'd3;
	localparam logic [2:0] DST_ANG  = 3'd4;

	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	// Tag that travels with each product through the multiplier register.
	typedef struct packed {
		logic       vld;
		logic [2:0] dest;
		logic [2:0] idx;
		logic       first;
		logic       neg;
	} mtag_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] v;
		unique case (i)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043837;
			5'd3:  v = 31'd133525159;
			5'd4:  v = 31'd67021687;
			5'd5:  v = 31'd33543516;
			5'd6:  v = 31'd16775851;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194283;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048576;
			5'd11: v = 31'd524288;
			5'd12: v = 31'd262144;
			5'd13: v = 31'd131072;
			5'd14: v = 31'd65536;
			5'd15: v = 31'd32768;
			5'd16: v = 31'd16384;
			5'd17: v = 31'd8192;
			5'd18: v = 31'd4096;
			5'd19: v = 31'd2048;
			5'd20: v = 31'd1024;
			5'd21: v = 31'd512;
			5'd22: v = 31'd256;
			5'd23: v = 31'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/phvc_if.sv]
// Channel interfaces of the pose-hold velocity controller: pose events in, velocities out.
`default_nettype none

interface phvc_pose_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic signed [31:0]  pos_x;
	logic signed [31:0]  pos_y;
	logic signed [31:0]  pos_z;
	logic [47:0]         rot_row0;
	logic [47:0]         rot_row1;
	logic [47:0]         rot_row2;

	modport source (output valid, func, pos_x, pos_y, pos_z, rot_row0, rot_row1, rot_row2,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, rot_row0, rot_row1, rot_row2,
		output ready);
endinterface

interface phvc_vel_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  lin_x;
	logic signed [31:0]  lin_y;
	logic signed [31:0]  lin_z;
	logic signed [31:0]  ang_x;
	logic signed [31:0]  ang_y;
	logic signed [31:0]  ang_z;

	modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
	modport sink (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

`default_nettype wire

[rtl/pose_hold_velocity_controller_core.sv]
// Pose-hold velocity controller: event decoding, offset, relative rotation, angle extraction and gain scaling.
//
// The pose channel takes one event item at a time: a pose sample, a save request or
// hold on/off. Control events and poses that are not worked on leave the channel ready
// again in the next cycle; a pose inside the deadband keeps it busy through the offset
// and the squared-distance test. A pose that yields a velocity item runs through a
// sequencer around one shared 34x30 multiplier, a bit-serial 29-step square root and
// one CORDIC stage: offset, deadband test (skipped when an offset component reaches
// one metre), relative rotation, square root and three CORDIC runs. The velocity item
// is then presented and the pose channel becomes ready again together with it. The pose
// channel is not ready meanwhile.
// The velocity channel has its own output register: a finished item waits there for
// the receiver while the next event is taken; if a second item finishes before the
// first is taken, the sequencer waits until the output register is free.
// The APB port writes and reads the gains and the deadband; it should be written only
// when the block is idle. Reset clears the checkpoint, the save and hold flags, and
// restores the default gains (5.0 and 0.25) and deadband (about 2 mm).
`default_nettype none

module pose_hold_velocity_controller_core (
	input  logic              clk,
	input  logic              arst_n,
	phvc_pose_if.sink         pose,
	phvc_vel_if.source        vel,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_ROT   = 4'd3;
	localparam logic [3:0] ST_ASAT  = 4'd4;
	localparam logic [3:0] ST_SQRT0 = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_CINIT = 4'd7;
	localparam logic [3:0] ST_CITER = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_DRAIN = 4'd10;
	localparam logic [3:0] ST_PUSH  = 4'd11;

	logic [3:0]          state_q;
	logic [15:0]         move_gain_q, turn_gain_q, deadband_q;
	logic                hold_on_q, have_ckpt_q, save_armed_q;
	logic [4:0]          cnt_q;
	logic [2:0]          rot_e_q;
	logic [1:0]          rot_m_q, run_q;
	logic                vel_vld_q;

	logic signed [31:0]  cur_pos_q [3];
	logic signed [31:0]  ckpt_pos_q [3];
	logic signed [15:0]  cur_rot_q [9];
	logic signed [15:0]  ckpt_rot_q [9];
	logic signed [32:0]  d_q [3];
	logic [33:0]         n2_q;
	logic signed [32:0]  r_q [5];
	logic signed [29:0]  a_q;
	logic [57:0]         v_q, res_q, bit_q;
	logic signed [35:0]  cx_q, cy_q;
	logic signed [33:0]  cz_q;
	logic signed [33:0]  ang_q [3];
	logic [31:0]         out_q [6];
	logic [31:0]         vel_q [6];

	logic signed [63:0]  prod_s1;
	phvc_pkg::mtag_t     tag_s1;

	logic                pose_acc, pose_nz, apb_wr, vel_load, big_any;
	logic signed [32:0]  d_next [3];
	logic signed [33:0]  mul_a;
	logic signed [29:0]  mul_b;
	logic signed [63:0]  mul_p;
	phvc_pkg::mtag_t     tag_d;
	logic signed [33:0]  neg_r20;
	logic signed [29:0]  a_next;
	logic [3:0]          c_idx, k_idx;
	logic [57:0]         sq_sum;
	logic signed [35:0]  ix, iy, xs, ys;
	logic signed [33:0]  at, z_next;
	logic signed [63:0]  sval;

	// Handshake decode.
	assign pose.ready = (state_q == ST_IDLE);
	assign pose_acc   = pose.valid && pose.ready;
	assign pose_nz    = (pose.pos_x != '0) || (pose.pos_y != '0) || (pose.pos_z != '0);
	assign apb_wr     = psel && penable && pwrite;
	assign pready     = 1'b1;
	assign vel_load   = (state_q == ST_PUSH) && (!vel_vld_q || vel.ready);

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			phvc_pkg::REG_MOVE_GAIN: prdata = {16'b0, move_gain_q};
			phvc_pkg::REG_TURN_GAIN: prdata = {16'b0, turn_gain_q};
			phvc_pkg::REG_DEADBAND:  prdata = {16'b0, deadband_q};
			default:                 prdata = '0;
		endcase
	end

	// Offset from the checkpoint and the coarse deadband test.
	always_comb begin
		big_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d_next[i] = 33'(cur_pos_q[i]) - 33'(ckpt_pos_q[i]);
			if (d_next[i] >= 33'sd65536 || d_next[i] <= -33'sd65536) begin
				big_any = 1'b1;
			end
		end
	end

	// Pitch argument, saturated to plus or minus one.
	always_comb begin
		neg_r20 = -(34'(r_q[2]));
		if (neg_r20 > 34'sd268435456) begin
			a_next = 30'sd268435456;
		end else if (neg_r20 < -34'sd268435456) begin
			a_next = -30'sd268435456;
		end else begin
			a_next = 30'(neg_r20);
		end
	end

	// Rows of the current and checkpoint rotations for each relative entry.
	always_comb begin
		unique case (rot_e_q)
			3'd0:    begin c_idx = 4'd0; k_idx = 4'd0; end
			3'd1:    begin c_idx = 4'd3; k_idx = 4'd0; end
			3'd2:    begin c_idx = 4'd6; k_idx = 4'd0; end
			3'd3:    begin c_idx = 4'd6; k_idx = 4'd3; end
			default: begin c_idx = 4'd6; k_idx = 4'd6; end
		endcase
		c_idx = c_idx + 4'(rot_m_q);
		k_idx = k_idx + 4'(rot_m_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		tag_d = '0;
		unique case (state_q)
			ST_SQ: begin
				if (cnt_q < 5'd3) begin
					mul_a = 34'(d_q[cnt_q[1:0]]);
					mul_b = 30'(d_q[cnt_q[1:0]]);
					tag_d.vld = 1'b1;
					tag_d.dest = phvc_pkg::DST_N2;
					tag_d.first = (cnt_q == 5'd0);
				end else begin
					mul_a = 34'({1'b0, deadband_q});
					mul_b = 30'({1'b0, deadband_q});
				end
			end
			ST_ROT: begin
				mul_a = 34'(cur_rot_q[c_idx]);
				mul_b = 30'(ckpt_rot_q[k_idx]);
				tag_d.vld = 1'b1;
				tag_d.dest = phvc_pkg::DST_ROT;
				tag_d.idx = rot_e_q;
				tag_d.first = (rot_m_q == 2'd0);
			end
			ST_ASAT: begin
				mul_a = 34'(a_next);
				mul_b = a_next;
			end
			ST_OUT: begin
				tag_d.vld = 1'b1;
				tag_d.idx = cnt_q[2:0];
				if (cnt_q < 5'd3) begin
					mul_b = 30'({1'b0, move_gain_q});
					tag_d.dest = phvc_pkg::DST_LIN;
				end else begin
					mul_b = 30'({1'b0, turn_gain_q});
					tag_d.dest = phvc_pkg::DST_ANG;
					tag_d.neg = 1'b1;
				end
				unique case (cnt_q[2:0])
					3'd0: mul_a = 34'(d_q[1]);
					3'd1: mul_a = 34'(d_q[0]);
					3'd2: begin mul_a = 34'(d_q[2]); tag_d.neg = 1'b1; end
					3'd3: mul_a = ang_q[2];
					3'd4: mul_a = ang_q[0];
					default: mul_a = ang_q[1];
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Square root step.
	assign sq_sum = res_q + bit_q;

	// CORDIC start vector with the quarter-turn pre-rotation.
	always_comb begin
		unique case (run_q)
			2'd0:    begin iy = 36'(a_q);    ix = 36'(res_q);  end
			2'd1:    begin iy = 36'(r_q[1]); ix = 36'(r_q[0]); end
			default: begin iy = 36'(r_q[3]); ix = 36'(r_q[4]); end
		endcase
	end

	// CORDIC vectoring step.
	always_comb begin
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		at = 34'({1'b0, phvc_pkg::atan_q30(cnt_q)});
		z_next = cy_q[35] ? (cz_q - at) : (cz_q + at);
	end

	// Signed product as seen by the output rounding.
	assign sval = tag_s1.neg ? -prod_s1 : prod_s1;

	// Control: flags, configuration, sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			move_gain_q  <= phvc_pkg::MOVE_GAIN_RST;
			turn_gain_q  <= phvc_pkg::TURN_GAIN_RST;
			deadband_q   <= phvc_pkg::DEADBAND_RST;
			hold_on_q    <= 1'b0;
			have_ckpt_q  <= 1'b0;
			save_armed_q <= 1'b0;
			cnt_q        <= '0;
			rot_e_q      <= '0;
			rot_m_q      <= '0;
			run_q        <= '0;
			vel_vld_q    <= 1'b0;
			tag_s1       <= '0;
		end else begin
			tag_s1 <= tag_d;
			if (apb_wr) begin
				unique case (paddr[3:2])
					phvc_pkg::REG_MOVE_GAIN: move_gain_q <= pwdata[15:0];
					phvc_pkg::REG_TURN_GAIN: turn_gain_q <= pwdata[15:0];
					phvc_pkg::REG_DEADBAND:  deadband_q  <= pwdata[15:0];
					default: ;
				endcase
			end
			if (vel_load) begin
				vel_vld_q <= 1'b1;
			end else if (vel.ready) begin
				vel_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pose_acc) begin
						unique case (pose.func)
							phvc_pkg::FUNC_SAVE:     save_armed_q <= 1'b1;
							phvc_pkg::FUNC_HOLD_ON:  hold_on_q <= 1'b1;
							phvc_pkg::FUNC_HOLD_OFF: hold_on_q <= 1'b0;
							default: begin
								if (pose_nz) begin
									if (save_armed_q) begin
										have_ckpt_q  <= 1'b1;
										save_armed_q <= 1'b0;
									end
									if ((have_ckpt_q || save_armed_q) && hold_on_q) begin
										state_q <= ST_DIFF;
									end
								end
							end
						endcase
					end
				end
				ST_DIFF: begin
					cnt_q   <= '0;
					rot_e_q <= '0;
					rot_m_q <= '0;
					state_q <= big_any ? ST_ROT : ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4) begin
						state_q <= (n2_q < prod_s1[33:0]) ? ST_IDLE : ST_ROT;
					end
				end
				ST_ROT: begin
					if (rot_m_q == 2'd2) begin
						rot_m_q <= '0;
						rot_e_q <= rot_e_q + 3'd1;
						if (rot_e_q == 3'd4) begin
							state_q <= ST_ASAT;
						end
					end else begin
						rot_m_q <= rot_m_q + 2'd1;
					end
				end
				ST_ASAT: state_q <= ST_SQRT0;
				ST_SQRT0: begin
					cnt_q   <= 5'd28;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						run_q   <= '0;
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					cnt_q   <= '0;
					state_q <= ST_CITER;
				end
				ST_CITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(phvc_pkg::CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						if (run_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							run_q   <= run_q + 2'd1;
							state_q <= ST_CINIT;
						end
					end
				end
				ST_OUT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (vel_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;

		// Capture of a pose and, when armed, of the checkpoint.
		if (pose_acc && pose.func == phvc_pkg::FUNC_POSE && pose_nz) begin
			cur_pos_q[0] <= pose.pos_x;
			cur_pos_q[1] <= pose.pos_y;
			cur_pos_q[2] <= pose.pos_z;
			for (int m = 0; m < 3; m++) begin
				cur_rot_q[m]     <= pose.rot_row0[16*m +: 16];
				cur_rot_q[3 + m] <= pose.rot_row1[16*m +: 16];
				cur_rot_q[6 + m] <= pose.rot_row2[16*m +: 16];
			end
			if (save_armed_q) begin
				ckpt_pos_q[0] <= pose.pos_x;
				ckpt_pos_q[1] <= pose.pos_y;
				ckpt_pos_q[2] <= pose.pos_z;
				for (int m = 0; m < 3; m++) begin
					ckpt_rot_q[m]     <= pose.rot_row0[16*m +: 16];
					ckpt_rot_q[3 + m] <= pose.rot_row1[16*m +: 16];
					ckpt_rot_q[6 + m] <= pose.rot_row2[16*m +: 16];
				end
			end
		end

		if (state_q == ST_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= d_next[i];
			end
		end

		if (state_q == ST_ASAT) begin
			a_q <= a_next;
		end

		// Bit-serial square root of one minus the squared pitch argument.
		if (state_q == ST_SQRT0) begin
			v_q   <= 58'h100_0000_0000_0000 - prod_s1[57:0];
			res_q <= '0;
			bit_q <= 58'h100_0000_0000_0000;
		end else if (state_q == ST_SQRT) begin
			if (v_q >= sq_sum) begin
				v_q   <= v_q - sq_sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		// CORDIC: pre-rotation, then one micro-rotation a cycle.
		if (state_q == ST_CINIT) begin
			if (ix < 0) begin
				if (iy >= 0) begin
					cx_q <= iy;
					cy_q <= -ix;
					cz_q <= phvc_pkg::HALF_PI_Q30;
				end else begin
					cx_q <= -iy;
					cy_q <= ix;
					cz_q <= -phvc_pkg::HALF_PI_Q30;
				end
			end else begin
				cx_q <= ix;
				cy_q <= iy;
				cz_q <= '0;
			end
		end else if (state_q == ST_CITER) begin
			if (!cy_q[35]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
			end
			cz_q <= z_next;
			if (cnt_q == 5'(phvc_pkg::CORDIC_STEPS - 1)) begin
				ang_q[run_q] <= z_next;
			end
		end

		// Products are written to their destinations from the multiplier register in the cycle after issue.
		if (tag_s1.vld) begin
			unique case (tag_s1.dest)
				phvc_pkg::DST_N2: begin
					n2_q <= tag_s1.first ? prod_s1[33:0] : n2_q + prod_s1[33:0];
				end
				phvc_pkg::DST_ROT: begin
					r_q[tag_s1.idx] <= tag_s1.first ? prod_s1[32:0]
						: r_q[tag_s1.idx] + prod_s1[32:0];
				end
				phvc_pkg::DST_LIN: begin
					out_q[tag_s1.idx] <= phvc_pkg::sat32((sval + 64'sd128) >>> 8);
				end
				phvc_pkg::DST_ANG: begin
					out_q[tag_s1.idx] <= phvc_pkg::sat32((sval + 64'sd2097152) >>> 22);
				end
				default: ;
			endcase
		end

		if (vel_load) begin
			for (int i = 0; i < 6; i++) begin
				vel_q[i] <= out_q[i];
			end
		end
	end

	// Velocity channel.
	assign vel.valid = vel_vld_q;
	assign vel.lin_x = vel_q[0];
	assign vel.lin_y = vel_q[1];
	assign vel.lin_z = vel_q[2];
	assign vel.ang_x = vel_q[3];
	assign vel.ang_y = vel_q[4];
	assign vel.ang_z = vel_q[5];

`ifndef NO_ASSERTIONS
	// A save request always leaves the block armed.
	a_save_arms: assert property (@(posedge clk) disable iff (!arst_n)
		pose_acc && pose.func == phvc_pkg::FUNC_SAVE |=> save_armed_q)
		else $error("save request did not arm the checkpoint");

	// Once a checkpoint is held it is never lost.
	a_ckpt_kept: assert property (@(posedge clk) disable iff (!arst_n)
		have_ckpt_q |=> have_ckpt_q)
		else $error("checkpoint flag dropped");

	// The sequencer only runs with a checkpoint held and hold enabled.
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> hold_on_q && have_ckpt_q)
		else $error("sequencer busy without hold and checkpoint");

	// A finished item reaches the output register and frees the sequencer.
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		vel_load |=> vel_vld_q && state_q == ST_IDLE)
		else $error("finished item not presented");
`endif

endmodule

`default_nettype wire
